// ===== hw/rtl/mtp_pkg.sv =====
// Shared types and constants for the mailbox transaction port.
// Holds the item and result word layouts, the access kinds and the status codes.
// No dependencies.
`default_nettype none

package mtp_pkg;

  // Buffer geometry
  localparam int BUFFER_BYTES = 4096;
  localparam int HEADER_BYTES = 4;
  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int PTR_W = $clog2(BUFFER_BYTES + 1);
  // Width that holds any 16-bit header length or buffer size for compares
  localparam int CMP_W = 17;

  localparam logic [7:0] NO_BYTE = 8'hFF;

  // Access kinds
  localparam logic [3:0] KIND_REQ = 4'd0;
  localparam logic [3:0] KIND_REWIND = 4'd1;
  localparam logic [3:0] KIND_EXEC = 4'd2;
  localparam logic [3:0] KIND_ABORT = 4'd3;
  localparam logic [3:0] KIND_STATUS = 4'd4;
  localparam logic [3:0] KIND_WR = 4'd5;
  localparam logic [3:0] KIND_RD = 4'd6;
  localparam logic [3:0] KIND_POLL = 4'd7;
  localparam logic [3:0] KIND_SRV_RD = 4'd8;
  localparam logic [3:0] KIND_SRV_WR = 4'd9;
  localparam logic [3:0] KIND_DONE = 4'd10;

  // Reported status codes
  localparam logic [2:0] STATUS_IDLE = 3'd0;
  localparam logic [2:0] STATUS_RECEIVING = 3'd1;
  localparam logic [2:0] STATUS_BUSY = 3'd2;
  localparam logic [2:0] STATUS_READY = 3'd3;
  localparam logic [2:0] STATUS_ABORTED = 3'd4;
  localparam logic [2:0] STATUS_NODRIVE = 3'd5;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  data_byte;
    logic [11:0] buffer_index;
    logic        drive_present;
    logic [31:0] snapshot_generation;
    logic [12:0] answer_length;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic        server_busy;
    logic [31:0] generation;
    logic [12:0] frame_length;
  } out_word_t;

  // Buffer access issued when an item is taken
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  // Result under construction; the byte comes from the buffer when use_ram is set
  typedef struct packed {
    logic      use_ram;
    out_word_t word;
  } stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mailbox_transaction_port_unit.sv =====
// Top level of the mailbox transaction port: handshake, result pipeline, frame buffer.
// Instantiates mtp_ctrl and mtp_ram. Uses mtp_pkg.
//
// Usage: host and server accesses arrive as one word on the item channel
// (item_valid / item_stall / item). Each accepted word yields exactly one
// result word on the result channel (result_valid / result_stall / result),
// in order.
// Path: the accepting edge applies the word to the mailbox state, issues
// the frame buffer access and loads the middle stage; the result register
// then catches the registered buffer read data once it is free.
// Throughput: one word per cycle while item_stall is low, set by the
// single-port frame buffer that takes one read or one write per cycle.
// Reset: rst clears the mailbox to idle, pointers, flags and generation to
// zero and empties the pipeline. Buffer contents are not cleared; no pass
// runs after reset and a word can be taken in the first cycle.
// Stall: while result_stall holds a waiting result, one more word can be
// taken into the middle stage; after that item_stall rises until the
// result is taken.
`default_nettype none

module mailbox_transaction_port_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire mtp_pkg::in_word_t  item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output mtp_pkg::out_word_t      result
);

  logic              accept;
  logic              out_free;
  logic              s1_valid;
  mtp_pkg::stage_t   s1;
  mtp_pkg::stage_t   stage;
  mtp_pkg::ram_req_t ram_req;
  logic [7:0]        ram_q;
  mtp_pkg::out_word_t out_next;

  // Handshake: the middle stage moves when the result register frees up
  assign out_free = !result_valid || !result_stall;
  assign item_stall = s1_valid && !out_free;
  assign accept = item_valid && !item_stall;

  mtp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .ram_req (ram_req),
    .stage   (stage)
  );

  mtp_ram #(
    .WIDTH (8),
    .DEPTH (mtp_pkg::BUFFER_BYTES)
  ) u_frame_buffer (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_q)
  );

  // Merge the buffer byte into the result
  always_comb begin
    out_next = s1.word;
    if (s1.use_ram) begin
      out_next.read_byte = ram_q;
    end
  end

  // Advance the middle stage and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (out_free) begin
        result_valid <= s1_valid;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage;
    end
    if (out_free && s1_valid) begin
      result <= out_next;
    end
  end

  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid)
    else $error("input stalled with nothing in flight");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1))
    else $error("middle stage lost a word under stall");

  a_read_tracks: assert property (@(posedge clk) disable iff (rst)
    accept && ram_req.re |=> s1_valid && s1.use_ram)
    else $error("buffer read issued without a result slot");

  a_busy_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.server_busy |-> result.status == mtp_pkg::STATUS_BUSY)
    else $error("server busy reported outside busy status");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> 17'(result.frame_length) <= 17'(mtp_pkg::BUFFER_BYTES))
    else $error("frame length past buffer size");

endmodule

`default_nettype wire

// ===== hw/rtl/mtp_ram.sv =====
// Generic single-port RAM with registered read data.
// Read data holds until the next read. No dependencies.
`default_nettype none

module mtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read through one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mtp_ctrl.sv =====
// Mailbox state, pointers, generation and header check for the transaction port.
// Applies one accepted word per cycle and issues the buffer access. Uses mtp_pkg.
`default_nettype none

module mtp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire mtp_pkg::in_word_t item,
  output mtp_pkg::ram_req_t     ram_req,
  output mtp_pkg::stage_t       stage
);

  localparam int AW = mtp_pkg::ADDR_W;
  localparam int PW = mtp_pkg::PTR_W;
  localparam int CW = mtp_pkg::CMP_W;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_RECEIVING = 5'b00010,
    ST_BUSY      = 5'b00100,
    ST_READY     = 5'b01000,
    ST_ABORTED   = 5'b10000
  } port_state_t;

  port_state_t state, state_next;
  logic [PW-1:0] wp, wp_next;
  logic [PW-1:0] rp, rp_next;
  logic [PW-1:0] slen, slen_next;
  logic          ovf, ovf_next;
  logic          sticky, sticky_next;
  logic [31:0]   gen, gen_next;
  logic [7:0]    hdr0, hdr1;
  logic [15:0]   declared;
  logic          idx_ok;
  logic [2:0]    state_code;
  logic [2:0]    shown;
  mtp_pkg::stage_t stage_body;

  assign declared = {hdr1, hdr0};
  assign idx_ok = CW'(item.buffer_index) < CW'(mtp_pkg::BUFFER_BYTES);

  // Apply the word to the mailbox state and pick the buffer access
  always_comb begin
    state_next = state;
    wp_next = wp;
    rp_next = rp;
    slen_next = slen;
    ovf_next = ovf;
    sticky_next = sticky;
    gen_next = gen;
    ram_req = '0;
    ram_req.wdata = item.data_byte;
    stage_body = '0;
    stage_body.word.read_byte = mtp_pkg::NO_BYTE;

    unique case (item.kind)
      mtp_pkg::KIND_REQ: begin
        if (state != ST_BUSY) begin
          wp_next = '0;
          rp_next = '0;
          ovf_next = 1'b0;
          sticky_next = 1'b0;
          gen_next = gen + 32'd1;
          state_next = ST_RECEIVING;
        end
      end
      mtp_pkg::KIND_REWIND: begin
        rp_next = '0;
      end
      mtp_pkg::KIND_EXEC: begin
        if (state != ST_BUSY) begin
          if (state != ST_RECEIVING || ovf || wp < PW'(mtp_pkg::HEADER_BYTES)) begin
            state_next = ST_ABORTED;
          end else if (CW'(declared) != CW'(wp) ||
                       CW'(declared) > CW'(mtp_pkg::BUFFER_BYTES)) begin
            state_next = ST_ABORTED;
          end else begin
            slen_next = wp;
            state_next = ST_BUSY;
          end
        end
      end
      mtp_pkg::KIND_ABORT: begin
        if (state == ST_BUSY) begin
          gen_next = gen + 32'd1;
        end
        sticky_next = 1'b1;
        state_next = ST_ABORTED;
      end
      mtp_pkg::KIND_STATUS: begin
      end
      mtp_pkg::KIND_WR: begin
        if (state == ST_RECEIVING) begin
          if (wp >= PW'(mtp_pkg::BUFFER_BYTES)) begin
            ovf_next = 1'b1;
          end else begin
            ram_req.we = 1'b1;
            ram_req.addr = wp[AW-1:0];
            wp_next = wp + PW'(1);
          end
        end
      end
      mtp_pkg::KIND_RD: begin
        if (state == ST_READY && !sticky && rp < slen &&
            rp < PW'(mtp_pkg::BUFFER_BYTES)) begin
          ram_req.re = 1'b1;
          ram_req.addr = rp[AW-1:0];
          rp_next = rp + PW'(1);
          stage_body.use_ram = 1'b1;
        end
      end
      mtp_pkg::KIND_POLL: begin
        stage_body.word.server_busy = (state == ST_BUSY);
        stage_body.word.generation = gen;
        stage_body.word.frame_length = 13'(slen);
      end
      mtp_pkg::KIND_SRV_RD: begin
        if (state == ST_BUSY && idx_ok) begin
          ram_req.re = 1'b1;
          ram_req.addr = AW'(item.buffer_index);
          stage_body.use_ram = 1'b1;
        end
      end
      mtp_pkg::KIND_SRV_WR: begin
        if (state == ST_BUSY && idx_ok) begin
          ram_req.we = 1'b1;
          ram_req.addr = AW'(item.buffer_index);
        end
      end
      mtp_pkg::KIND_DONE: begin
        if (state == ST_BUSY && item.snapshot_generation == gen) begin
          slen_next = (CW'(item.answer_length) > CW'(mtp_pkg::BUFFER_BYTES)) ?
                      PW'(mtp_pkg::BUFFER_BYTES) : PW'(item.answer_length);
          state_next = ST_READY;
        end
      end
      default: begin
      end
    endcase

    // Gate the buffer access on the handshake
    if (!accept) begin
      ram_req.we = 1'b1 & 1'b0;
      ram_req.re = 1'b0;
    end
  end

  // Report the status as it stands after this word
  always_comb begin
    unique case (state_next)
      ST_IDLE:      state_code = mtp_pkg::STATUS_IDLE;
      ST_RECEIVING: state_code = mtp_pkg::STATUS_RECEIVING;
      ST_BUSY:      state_code = mtp_pkg::STATUS_BUSY;
      ST_READY:     state_code = mtp_pkg::STATUS_READY;
      ST_ABORTED:   state_code = mtp_pkg::STATUS_ABORTED;
      default:      state_code = mtp_pkg::STATUS_IDLE;
    endcase
    shown = sticky_next ? mtp_pkg::STATUS_ABORTED : state_code;
    if ((shown == mtp_pkg::STATUS_IDLE || shown == mtp_pkg::STATUS_ABORTED) &&
        !item.drive_present) begin
      shown = mtp_pkg::STATUS_NODRIVE;
    end
  end

  // Put the status into the result under construction
  always_comb begin
    stage = stage_body;
    stage.word.status = shown;
  end

  // Commit the state on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp <= '0;
      rp <= '0;
      slen <= '0;
      ovf <= 1'b0;
      sticky <= 1'b0;
      gen <= '0;
    end else if (accept) begin
      state <= state_next;
      wp <= wp_next;
      rp <= rp_next;
      slen <= slen_next;
      ovf <= ovf_next;
      sticky <= sticky_next;
      gen <= gen_next;
    end
  end

  // Shadow the length header as the host writes it
  always_ff @(posedge clk) begin
    if (accept && ram_req.we && item.kind == mtp_pkg::KIND_WR) begin
      if (wp == PW'(0)) begin
        hdr0 <= item.data_byte;
      end
      if (wp == PW'(1)) begin
        hdr1 <= item.data_byte;
      end
    end
  end

  a_busy_no_sticky: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUSY |-> !sticky)
    else $error("busy state with sticky abort set");

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    wp <= PW'(mtp_pkg::BUFFER_BYTES))
    else $error("write pointer past buffer");

  a_gen_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(gen))
    else $error("generation moved without an accepted word");

endmodule

`default_nettype wire
